[rtl/core/irot_pkg.sv]
package irot_pkg;

    // Frame geometry
    localparam int MAX_SIDE   = 256;
    localparam int PIXEL_BITS = 24;
    localparam int CRD_W      = $clog2(MAX_SIDE);
    localparam int DIM_W      = CRD_W + 1;
    localparam int ADDR_W     = 2 * CRD_W;
    localparam int FS_DEPTH   = MAX_SIDE * MAX_SIDE;

    // Configuration port
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_IMG_WIDTH     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_IMG_HEIGHT    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SEL_LEFT      = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SEL_TOP       = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SEL_RIGHT     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SEL_BOTTOM    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_QUARTER_TURNS = 3'd6;

    // Transaction codes
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_UNSUP = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;

    typedef struct packed {
        logic                  action;
        logic [CRD_W-1:0]      row;
        logic [CRD_W-1:0]      col;
        logic [PIXEL_BITS-1:0] pixel;
    } req_t;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] read_pixel;
        logic [1:0]            status;
        logic [DIM_W-1:0]      result_width;
        logic [DIM_W-1:0]      result_height;
    } rsp_t;

endpackage

[rtl/core/image_quarter_turn_rotator.sv]
// Path: the accepting edge registers the frame-store read into stage 1; the result
// then moves to the output register once that register is free.
// Throughput: one transaction per cycle unless a response stall holds stage 1,
// set by the one frame-store access (one write or one registered read per cycle).
// Reset: configuration returns to full 256x256 image, whole selection, no turn;
// the pipeline empties. Frame-store contents are not cleared by reset.
module image_quarter_turn_rotator (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [irot_pkg::PADDR_W-1:0]    paddr,
    input  logic [irot_pkg::PDATA_W-1:0]    pwdata,
    output logic [irot_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  irot_pkg::req_t                  req,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output irot_pkg::rsp_t                  rsp
);

    import irot_pkg::*;

    // Configuration registers
    logic [DIM_W-1:0] img_width_reg;
    logic [DIM_W-1:0] img_height_reg;
    logic [CRD_W-1:0] sel_left_reg;
    logic [CRD_W-1:0] sel_top_reg;
    logic [DIM_W-1:0] sel_right_reg;
    logic [DIM_W-1:0] sel_bottom_reg;
    logic [1:0]       quarter_turns_reg;

    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[REG_IDX_W+1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_width_reg     <= DIM_W'(MAX_SIDE);
            img_height_reg    <= DIM_W'(MAX_SIDE);
            sel_left_reg      <= '0;
            sel_top_reg       <= '0;
            sel_right_reg     <= DIM_W'(MAX_SIDE);
            sel_bottom_reg    <= DIM_W'(MAX_SIDE);
            quarter_turns_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_IMG_WIDTH:     img_width_reg     <= pwdata[DIM_W-1:0];
                REG_IMG_HEIGHT:    img_height_reg    <= pwdata[DIM_W-1:0];
                REG_SEL_LEFT:      sel_left_reg      <= pwdata[CRD_W-1:0];
                REG_SEL_TOP:       sel_top_reg       <= pwdata[CRD_W-1:0];
                REG_SEL_RIGHT:     sel_right_reg     <= pwdata[DIM_W-1:0];
                REG_SEL_BOTTOM:    sel_bottom_reg    <= pwdata[DIM_W-1:0];
                REG_QUARTER_TURNS: quarter_turns_reg <= pwdata[1:0];
                default:           ;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        unique case (cfg_idx)
            REG_IMG_WIDTH:     prdata = PDATA_W'(img_width_reg);
            REG_IMG_HEIGHT:    prdata = PDATA_W'(img_height_reg);
            REG_SEL_LEFT:      prdata = PDATA_W'(sel_left_reg);
            REG_SEL_TOP:       prdata = PDATA_W'(sel_top_reg);
            REG_SEL_RIGHT:     prdata = PDATA_W'(sel_right_reg);
            REG_SEL_BOTTOM:    prdata = PDATA_W'(sel_bottom_reg);
            REG_QUARTER_TURNS: prdata = PDATA_W'(quarter_turns_reg);
            default:           prdata = '0;
        endcase
    end

    // Clamped image size and selection classification
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic             whole;
    logic             square;
    logic [DIM_W-1:0] rw;
    logic [DIM_W-1:0] rh;

    always_comb
    begin
        if (img_width_reg == '0)
            w = DIM_W'(1);
        else if (img_width_reg > DIM_W'(MAX_SIDE))
            w = DIM_W'(MAX_SIDE);
        else
            w = img_width_reg;

        if (img_height_reg == '0)
            h = DIM_W'(1);
        else if (img_height_reg > DIM_W'(MAX_SIDE))
            h = DIM_W'(MAX_SIDE);
        else
            h = img_height_reg;

        whole = (sel_left_reg == '0) && (sel_top_reg == '0) &&
                (sel_right_reg == w) && (sel_bottom_reg == h);
        square = (sel_right_reg > {1'b0, sel_left_reg}) &&
                 (sel_bottom_reg > {1'b0, sel_top_reg}) &&
                 (sel_right_reg <= w) && (sel_bottom_reg <= h) &&
                 ((sel_right_reg - {1'b0, sel_left_reg}) ==
                  (sel_bottom_reg - {1'b0, sel_top_reg}));

        if (whole && quarter_turns_reg[0])
        begin
            rw = h;
            rh = w;
        end
        else
        begin
            rw = w;
            rh = h;
        end
    end

    // Address mapping for the incoming transaction
    logic             accept;
    logic             fs_we;
    logic             fs_re;
    logic [1:0]       status_c;
    logic [DIM_W-1:0] row9;
    logic [DIM_W-1:0] col9;
    logic [DIM_W-1:0] left9;
    logic [DIM_W-1:0] top9;
    logic [DIM_W-1:0] s1;
    logic [DIM_W-1:0] dr;
    logic [DIM_W-1:0] dc;
    logic [DIM_W-1:0] sr;
    logic [DIM_W-1:0] sc;
    logic             in_sel;

    assign accept = req_valid && !req_stall;

    always_comb
    begin
        row9   = {1'b0, req.row};
        col9   = {1'b0, req.col};
        left9  = {1'b0, sel_left_reg};
        top9   = {1'b0, sel_top_reg};
        s1     = sel_right_reg - left9 - DIM_W'(1);
        dr     = row9 - top9;
        dc     = col9 - left9;
        in_sel = (row9 >= top9) && (row9 < sel_bottom_reg) &&
                 (col9 >= left9) && (col9 < sel_right_reg);
        sr     = row9;
        sc     = col9;

        if (whole)
        begin
            unique case (quarter_turns_reg)
                2'd1:
                begin
                    sr = h - DIM_W'(1) - col9;
                    sc = row9;
                end
                2'd2:
                begin
                    sr = h - DIM_W'(1) - row9;
                    sc = w - DIM_W'(1) - col9;
                end
                2'd3:
                begin
                    sr = col9;
                    sc = w - DIM_W'(1) - row9;
                end
                default: ;
            endcase
        end
        else if (in_sel)
        begin
            unique case (quarter_turns_reg)
                2'd1:
                begin
                    sr = top9 + s1 - dc;
                    sc = left9 + dr;
                end
                2'd2:
                begin
                    sr = top9 + s1 - dr;
                    sc = left9 + s1 - dc;
                end
                2'd3:
                begin
                    sr = top9 + dc;
                    sc = left9 + s1 - dr;
                end
                default: ;
            endcase
        end

        // Status and memory strobes
        fs_we = 1'b0;
        fs_re = 1'b0;
        if (req.action == ACT_WRITE)
        begin
            if ((row9 < h) && (col9 < w))
            begin
                status_c = STAT_OK;
                fs_we    = accept;
            end
            else
            begin
                status_c = STAT_RANGE;
            end
        end
        else if (!whole && !square)
        begin
            status_c = STAT_UNSUP;
        end
        else if ((row9 >= rh) || (col9 >= rw))
        begin
            status_c = STAT_RANGE;
        end
        else
        begin
            status_c = STAT_OK;
            fs_re    = accept;
        end
    end

    // Frame store
    logic [PIXEL_BITS-1:0] fs_rdata;

    irot_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (FS_DEPTH)
    ) u_frame_store (
        .clk   (clk),
        .we    (fs_we),
        .waddr ({req.row, req.col}),
        .wdata (req.pixel),
        .re    (fs_re),
        .raddr ({sr[CRD_W-1:0], sc[CRD_W-1:0]}),
        .rdata (fs_rdata)
    );

    // Stage 1: transaction waiting on the frame-store read
    logic             p1_valid_reg;
    logic             p1_use_pix_reg;
    logic [1:0]       p1_status_reg;
    logic [DIM_W-1:0] p1_rw_reg;
    logic [DIM_W-1:0] p1_rh_reg;
    logic             p1_adv;
    logic             out_free;

    assign out_free  = !rsp_valid || !rsp_stall;
    assign p1_adv    = p1_valid_reg && out_free;
    assign req_stall = p1_valid_reg && !out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            p1_valid_reg <= 1'b1;
        end
        else if (p1_adv)
        begin
            p1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p1_use_pix_reg <= fs_re;
            p1_status_reg  <= status_c;
            p1_rw_reg      <= rw;
            p1_rh_reg      <= rh;
        end
    end

    // Output register
    logic rsp_valid_reg;
    rsp_t rsp_reg;
    rsp_t rsp_next;

    always_comb
    begin
        rsp_next.read_pixel    = p1_use_pix_reg ? fs_rdata : '0;
        rsp_next.status        = p1_status_reg;
        rsp_next.result_width  = p1_rw_reg;
        rsp_next.result_height = p1_rh_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            rsp_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p1_adv)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Checks
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (p1_valid_reg && rsp_valid_reg))
        else $error("input stalled while pipeline has room");

    a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> p1_valid_reg)
        else $error("accepted transaction lost from stage 1");

    a_fail_zero_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status != STAT_OK)) |-> (rsp.read_pixel == '0))
        else $error("failed transaction returned a pixel");

    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        !(fs_we && fs_re))
        else $error("frame store written and read in one cycle");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (p1_valid_reg && !p1_adv) |=> (p1_valid_reg && $stable(p1_status_reg)))
        else $error("stalled stage 1 transaction changed");

endmodule

[rtl/core/irot_ram.sv]
module irot_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[tb/rotation_checker.sv]
`timescale 1ns / 100ps
module rotation_checker
    import irot_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    input  logic               req_valid,
    input  logic               req_stall,
    input  req_t               req,
    input  logic               rsp_valid,
    input  logic               rsp_stall,
    input  rsp_t               rsp,
    output int                 err_count,
    output int                 outstanding
);

    // Local copy of the configuration registers
    logic [DIM_W-1:0] img_width;
    logic [DIM_W-1:0] img_height;
    logic [CRD_W-1:0] sel_left;
    logic [CRD_W-1:0] sel_top;
    logic [DIM_W-1:0] sel_right;
    logic [DIM_W-1:0] sel_bottom;
    logic [1:0]       quarter_turns;

    // Mirror of the frame store, and responses the block still owes
    logic [PIXEL_BITS-1:0] frame_copy [FS_DEPTH];
    rsp_t                  owed_rsp [$];

    function automatic int clamp_side(logic [DIM_W-1:0] v);
        if (v == '0)
            return 1;
        if (v > MAX_SIDE)
            return MAX_SIDE;
        return int'(v);
    endfunction

    // Expected response for one transaction; a write also updates the mirror
    function automatic rsp_t rotate_access(req_t t);
        int   w, h, rw, rh, r, c, sr, sc, s1, dr, dc;
        int   lft, tp, rgt, bot;
        bit   whole, square;
        rsp_t o;
        w     = clamp_side(img_width);
        h     = clamp_side(img_height);
        lft   = sel_left;
        tp    = sel_top;
        rgt   = sel_right;
        bot   = sel_bottom;
        r     = t.row;
        c     = t.col;
        whole = lft == 0 && tp == 0 && rgt == w && bot == h;
        square = rgt > lft && bot > tp && rgt <= w && bot <= h &&
                 (rgt - lft) == (bot - tp);
        rw = w;
        rh = h;
        if (whole && quarter_turns[0])
        begin
            rw = h;
            rh = w;
        end
        o        = '0;
        o.status = STAT_OK;
        if (t.action == ACT_WRITE)
        begin
            if (r < h && c < w)
                frame_copy[r * MAX_SIDE + c] = t.pixel;
            else
                o.status = STAT_RANGE;
        end
        else if (!whole && !square)
            o.status = STAT_UNSUP;
        else if (r >= rh || c >= rw)
            o.status = STAT_RANGE;
        else
        begin
            sr = r;
            sc = c;
            if (whole)
            begin
                case (quarter_turns)
                    2'd1: begin sr = h - 1 - c; sc = r;         end
                    2'd2: begin sr = h - 1 - r; sc = w - 1 - c; end
                    2'd3: begin sr = c;         sc = w - 1 - r; end
                    default: ;
                endcase
            end
            else if (r >= tp && r < bot && c >= lft && c < rgt)
            begin
                // turn inside the square, offsets relative to its corner
                s1 = rgt - lft - 1;
                dr = r - tp;
                dc = c - lft;
                case (quarter_turns)
                    2'd1: begin sr = tp + s1 - dc; sc = lft + dr;      end
                    2'd2: begin sr = tp + s1 - dr; sc = lft + s1 - dc; end
                    2'd3: begin sr = tp + dc;      sc = lft + s1 - dr; end
                    default: ;
                endcase
            end
            o.read_pixel = frame_copy[sr * MAX_SIDE + sc];
        end
        o.result_width  = rw[DIM_W-1:0];
        o.result_height = rh[DIM_W-1:0];
        return o;
    endfunction

    task automatic flag_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            err_count++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                     $time, name, want, got);
        end
    endtask

    // Track config writes, predict on request, compare on response
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            img_width     = 9'd256;
            img_height    = 9'd256;
            sel_left      = '0;
            sel_top       = '0;
            sel_right     = 9'd256;
            sel_bottom    = 9'd256;
            quarter_turns = '0;
            owed_rsp.delete();
            outstanding <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[PADDR_W-1:2])
                    REG_IMG_WIDTH:     img_width     = pwdata[DIM_W-1:0];
                    REG_IMG_HEIGHT:    img_height    = pwdata[DIM_W-1:0];
                    REG_SEL_LEFT:      sel_left      = pwdata[CRD_W-1:0];
                    REG_SEL_TOP:       sel_top       = pwdata[CRD_W-1:0];
                    REG_SEL_RIGHT:     sel_right     = pwdata[DIM_W-1:0];
                    REG_SEL_BOTTOM:    sel_bottom    = pwdata[DIM_W-1:0];
                    REG_QUARTER_TURNS: quarter_turns = pwdata[1:0];
                    default: ;
                endcase
            end
            if (req_valid && !req_stall)
                owed_rsp.push_back(rotate_access(req));
            if (rsp_valid && !rsp_stall)
            begin
                if (owed_rsp.size() == 0)
                begin
                    err_count++;
                    $display("%0t: response mismatch, expected none, got 0x%0h",
                             $time, rsp);
                end
                else
                begin
                    want = owed_rsp.pop_front();
                    flag_field("read_pixel", 32'(want.read_pixel), 32'(rsp.read_pixel));
                    flag_field("status", 32'(want.status), 32'(rsp.status));
                    flag_field("result_width", 32'(want.result_width),
                               32'(rsp.result_width));
                    flag_field("result_height", 32'(want.result_height),
                               32'(rsp.result_height));
                end
            end
            outstanding <= owed_rsp.size();
        end
    end

endmodule

[tb/tb_image_quarter_turn_rotator.sv]
`timescale 1ns / 100ps
module tb_image_quarter_turn_rotator;
    import irot_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int TARGET_ITEMS = 550;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [PADDR_W-1:0] paddr     = '0;
    logic [PDATA_W-1:0] pwdata    = '0;
    logic               req_valid = 1'b0;
    req_t               req       = '0;
    logic               rsp_stall = 1'b0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               req_stall;
    logic               rsp_valid;
    rsp_t               rsp;
    int                 err_count;
    int                 outstanding;

    // Stimulus view of the image size, and which pixels hold data
    int eff_w = MAX_SIDE;
    int eff_h = MAX_SIDE;
    bit written [FS_DEPTH];
    bit no_gaps = 1'b0;
    int idle_cycles = 0;
    int sent_items = 0;

    image_quarter_turn_rotator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    rotation_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .err_count   (err_count),
        .outstanding (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: cycles with no transaction on any port
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("image_quarter_turn_rotator verification failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Response back-pressure: free-running runs, short stalls, rare long ones
    initial
    begin
        int run;
        int hold;
        forever
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: run = $urandom_range(1, 4);
                5, 6, 7:       run = $urandom_range(5, 20);
                default:       run = $urandom_range(30, 120);
            endcase
            rsp_stall <= 1'b0;
            repeat (run) @(posedge clk);
            case ($urandom_range(0, 19))
                0:                   hold = $urandom_range(20, 60);
                1, 2, 3, 4, 5:       hold = $urandom_range(3, 8);
                default:             hold = $urandom_range(0, 2);
            endcase
            if (hold > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic int side(int v);
        if (v == 0)
            return 1;
        if (v > MAX_SIDE)
            return MAX_SIDE;
        return v;
    endfunction

    // One request transaction, then an optional gap
    task automatic send(logic act, int row, int col, logic [PIXEL_BITS-1:0] pix);
        req_t t;
        int   g;
        t.action = act;
        t.row    = CRD_W'(row);
        t.col    = CRD_W'(col);
        t.pixel  = pix;
        req_valid <= 1'b1;
        req       <= t;
        do
            @(posedge clk);
        while (req_stall);
        sent_items++;
        if (act == ACT_WRITE && row < eff_h && col < eff_w)
            written[row * MAX_SIDE + col] = 1'b1;
        g = pick_gap();
        if (g > 0)
        begin
            req_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // Hold off requests until every response has come back
    task automatic drain();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    task automatic set_reg(logic [REG_IDX_W-1:0] idx, int val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= PDATA_W'(val);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
    endtask

    task automatic configure(int wr, int hr, int l, int t, int r, int b, int q);
        set_reg(REG_IMG_WIDTH, wr);
        set_reg(REG_IMG_HEIGHT, hr);
        set_reg(REG_SEL_LEFT, l);
        set_reg(REG_SEL_TOP, t);
        set_reg(REG_SEL_RIGHT, r);
        set_reg(REG_SEL_BOTTOM, b);
        set_reg(REG_QUARTER_TURNS, q);
        psel    <= 1'b0;
        penable <= 1'b0;
        eff_w = side(wr & 9'h1FF);
        eff_h = side(hr & 9'h1FF);
    endtask

    initial
    begin
        int wr, hr, w, h, l, t, r, b, s, n, span, row, col;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: corners of the full 256x256 frame, every turn
        send(ACT_WRITE, 0, 0, 24'h000000);
        send(ACT_WRITE, 255, 255, 24'hFFFFFF);
        send(ACT_WRITE, 0, 255, 24'hA5A5A5);
        send(ACT_WRITE, 255, 0, 24'h5A5A5A);
        send(ACT_READ, 0, 0, 24'hFFFFFF);
        send(ACT_READ, 255, 255, 24'h000000);
        send(ACT_READ, 0, 255, 24'h000000);
        drain();
        configure(256, 256, 0, 0, 256, 256, 1);
        send(ACT_READ, 0, 0, 0);
        send(ACT_READ, 0, 255, 0);
        send(ACT_READ, 255, 0, 0);
        drain();
        configure(256, 256, 0, 0, 256, 256, 2);
        send(ACT_READ, 0, 0, 0);
        send(ACT_READ, 255, 255, 0);
        drain();
        configure(256, 256, 0, 0, 256, 256, 3);
        send(ACT_READ, 0, 0, 0);
        send(ACT_READ, 255, 255, 0);
        // zero size clamps to 1x1; old selection no longer fits
        drain();
        configure(0, 0, 0, 0, 256, 256, 0);
        send(ACT_WRITE, 0, 1, 24'h123456);
        send(ACT_READ, 0, 0, 0);
        // whole 1x1 image, read beyond the result
        drain();
        configure(0, 0, 0, 0, 1, 1, 1);
        send(ACT_READ, 0, 0, 0);
        send(ACT_READ, 1, 0, 0);
        // oversize clamps to 256
        drain();
        configure(511, 300, 0, 0, 256, 256, 3);
        send(ACT_READ, 255, 0, 0);
        // one-pixel square in the far corner
        drain();
        configure(256, 256, 255, 255, 256, 256, 2);
        send(ACT_READ, 255, 255, 0);
        send(ACT_READ, 0, 0, 0);

        // Random phases: new geometry, fill the image, then mixed traffic
        while (sent_items < TARGET_ITEMS)
        begin
            drain();
            case ($urandom_range(0, 9))
                0:       begin wr = 256;                     hr = 1;                     end
                1:       begin wr = 1;                       hr = 256;                   end
                2:       begin wr = 0;                       hr = $urandom_range(1, 16); end
                3:       begin wr = $urandom_range(257, 511); hr = $urandom_range(0, 1); end
                default: begin wr = $urandom_range(1, 12);   hr = $urandom_range(1, 12); end
            endcase
            w = side(wr);
            h = side(hr);
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    l = 0; t = 0; r = w; b = h;
                end
                4, 5, 6, 7:
                begin
                    s = $urandom_range(1, (w < h) ? w : h);
                    l = $urandom_range(0, w - s);
                    t = $urandom_range(0, h - s);
                    r = l + s;
                    b = t + s;
                end
                8:
                begin
                    l = $urandom_range(0, 255);
                    t = $urandom_range(0, 255);
                    r = $urandom_range(0, 511);
                    b = $urandom_range(0, 511);
                end
                default:
                begin
                    l = 0; t = 0; r = (w > 1) ? w - 1 : w; b = h;
                end
            endcase
            configure(wr, hr, l, t, r, b, $urandom_range(0, 3));
            for (int fr = 0; fr < eff_h; fr++)
                for (int fc = 0; fc < eff_w; fc++)
                    if (!written[fr * MAX_SIDE + fc])
                        send(ACT_WRITE, fr, fc, PIXEL_BITS'($urandom));
            no_gaps = ($urandom_range(0, 3) == 0);
            n = $urandom_range(25, 45);
            span = (eff_w > eff_h) ? eff_w : eff_h;
            repeat (n)
            begin
                if (sent_items >= TARGET_ITEMS)
                    break;
                if ($urandom_range(0, 3) != 0)
                begin
                    row = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                      : $urandom_range(0, span - 1);
                    col = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                      : $urandom_range(0, span - 1);
                    send(ACT_READ, row, col, PIXEL_BITS'($urandom));
                end
                else
                begin
                    if ($urandom_range(0, 99) < 85)
                    begin
                        row = $urandom_range(0, eff_h - 1);
                        col = $urandom_range(0, eff_w - 1);
                    end
                    else
                    begin
                        row = $urandom_range(0, 255);
                        col = $urandom_range(0, 255);
                    end
                    send(ACT_WRITE, row, col, PIXEL_BITS'($urandom));
                end
            end
        end
        no_gaps = 1'b0;

        // Let the pipeline empty, then a short settle
        drain();
        repeat (8) @(posedge clk);
        if (err_count == 0 && outstanding == 0)
            $display("image_quarter_turn_rotator verification clean");
        else
            $display("image_quarter_turn_rotator verification failed");
        $finish;
    end

endmodule
